// ----- rtl/dlts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the delta-list task scheduler.
// Used by dlts_div, dlts_cell and the top level; depends on nothing.
package dlts_pkg;

  localparam int DEPTH   = 16;
  localparam int TICK_MS = 10;

  localparam int REQ_W  = 2;
  localparam int TASK_W = 8;
  localparam int TIME_W = 24;
  localparam int RUNS_W = 8;
  localparam int POS_W  = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);

  // rounded-up reciprocal of TICK_MS; exact quotient for every TIME_W-bit dividend
  localparam int DIV_SHIFT = TIME_W + $clog2(TICK_MS);
  localparam logic [TIME_W:0] DIV_MUL =
      (TIME_W + 1)'(((64'd1 << DIV_SHIFT) + 64'(TICK_MS - 1)) / 64'(TICK_MS));

  localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD      = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd2;

  localparam logic [RUNS_W-1:0] RUNS_MAX = {RUNS_W{1'b1}};

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] period;
    logic [RUNS_W-1:0] runs;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_LEFT,
    CELL_LOAD_LEFT_SUB,
    CELL_LOAD_RIGHT,
    CELL_LOAD_NEW,
    CELL_TICK,
    CELL_BUMP
  } cell_cmd_e;

endpackage

// ----- rtl/dlts_div.sv -----
`timescale 1ns / 1ps
// Divide by the constant TICK_MS through a multiply by its reciprocal; the result is ready in the cycle after start.
// Depends on dlts_pkg.
module dlts_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dlts_pkg::TIME_W-1:0] dividend_i,
  output logic                        done_o,
  output logic [dlts_pkg::TIME_W-1:0] quotient_o
);
  import dlts_pkg::*;

  logic              done_q;
  logic [TIME_W-1:0] quo_q, quo_d;
  logic [2*TIME_W:0] prod;

  // keep the product bits above the reciprocal's shift
  assign prod  = {{(TIME_W + 1){1'b0}}, dividend_i} * {{TIME_W{1'b0}}, DIV_MUL};
  assign quo_d = start_i ? TIME_W'(prod >> DIV_SHIFT) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/dlts_cell.sv -----
`timescale 1ns / 1ps
// One slot of the delta list: holds an entry and takes one from a neighbor on command.
// Depends on dlts_pkg.
module dlts_cell (
  input  logic                        clk_i,
  input  dlts_pkg::cell_cmd_e         cmd_i,
  input  dlts_pkg::entry_t            left_i,
  input  dlts_pkg::entry_t            right_i,
  input  dlts_pkg::entry_t            new_i,
  input  logic [dlts_pkg::TIME_W-1:0] sub_i,
  output dlts_pkg::entry_t            entry_o
);
  import dlts_pkg::*;

  entry_t            ent_q, ent_d;
  logic [TIME_W-1:0] dec_delta;

  assign dec_delta = (ent_q.delta != '0) ? ent_q.delta - 1'b1 : ent_q.delta;

  always_comb begin
    ent_d = ent_q;
    case (cmd_i)
      CELL_HOLD:      ent_d = ent_q;
      CELL_LOAD_LEFT: ent_d = left_i;
      CELL_LOAD_LEFT_SUB: begin
        ent_d       = left_i;
        ent_d.delta = left_i.delta - sub_i;
      end
      CELL_LOAD_RIGHT: ent_d = right_i;
      CELL_LOAD_NEW:   ent_d = new_i;
      CELL_TICK: begin
        ent_d.delta = dec_delta;
        if (dec_delta == '0 && ent_q.runs != RUNS_MAX) begin
          ent_d.runs = ent_q.runs + 1'b1;
        end
      end
      CELL_BUMP: begin
        if (ent_q.runs != RUNS_MAX) begin
          ent_d.runs = ent_q.runs + 1'b1;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign entry_o = ent_q;

endmodule

// ----- rtl/delta_list_task_scheduler.sv -----
`timescale 1ns / 1ps
// Top level of the delta-list task scheduler: request sequencer over a row of slot cells.
// Depends on dlts_pkg, dlts_div and dlts_cell.
//
//  channel  | dir | tuser              | tdata
//  ---------+-----+--------------------+-------------------------------------------
//  s_axis   | in  | req_type           | task_id, delay_ms, period_ms
//  m_axis   | out | add_accepted,fired | fired_task_id, queued
//
// Tick and refused or idle requests go straight to the result; an add passes through
// the reciprocal divide by TICK_MS and then walks past each entry whose due time is
// not later; a dispatch of a periodic task walks past the entries the same way.
// The insertion walk compares one slot a cycle; insert and pop shift the whole row
// in parallel. Reset clears only the sequencer, the entry count, the output valid
// and the divider done flags, no sweep. A new request is taken while the previous
// result still waits on m_axis; a result that cannot leave holds the sequencer.
module delta_list_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // task_id[7:0], delay_ms[31:8], period_ms[55:32]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // fired_task_id[7:0], queued[12:8], zero fill
  output logic [1:0]  m_axis_tuser    // add_accepted[0], fired[1]
);
  import dlts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic              fix_q, fix_d;
  logic [REQ_W-1:0]  req_q, req_d;
  entry_t            ins_q, ins_d;
  logic [TIME_W-1:0] delay_ms_q, period_ms_q;
  logic              res_acc_q, res_acc_d;
  logic              res_fired_q, res_fired_d;
  logic [TASK_W-1:0] res_id_q, res_id_d;

  logic              m_valid_q, m_valid_d;
  logic              out_acc_q, out_fired_q;
  logic [TASK_W-1:0] out_id_q;
  logic [4:0]        out_queued_q;

  entry_t            cell_ent [DEPTH];
  cell_cmd_e         cell_cmd [DEPTH];
  entry_t            walk_ent;
  logic              walk_more;
  logic              do_insert, do_pop, do_tick, do_bump;
  logic              div_start, div_done, div_done_per;
  logic [TIME_W-1:0] q_delay, q_period;
  logic [31:0]       occ_ext;
  logic              s_fire;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign walk_ent  = cell_ent[pos_q];
  assign walk_more = (OCC_W'(pos_q) < occ_q) && (rem_q >= walk_ent.delta);

  dlts_div u_div_delay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (delay_ms_q),
    .done_o     (div_done),
    .quotient_o (q_delay)
  );

  dlts_div u_div_period (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (period_ms_q),
    .done_o     (div_done_per),
    .quotient_o (q_period)
  );

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    fix_d       = fix_q;
    req_d       = req_q;
    ins_d       = ins_q;
    res_acc_d   = res_acc_q;
    res_fired_d = res_fired_q;
    res_id_d    = res_id_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    do_insert   = 1'b0;
    do_pop      = 1'b0;
    do_tick     = 1'b0;
    do_bump     = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          req_d       = s_axis_tuser;
          res_acc_d   = 1'b0;
          res_fired_d = 1'b0;
          res_id_d    = '0;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        fix_d   = 1'b0;
        pos_d   = '0;
        case (req_q)
          REQ_TICK: begin
            do_tick = (occ_q != '0);
          end
          REQ_ADD: begin
            if (occ_q != OCC_W'(DEPTH)) begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          REQ_DISPATCH: begin
            if (occ_q != '0 && cell_ent[0].runs != '0) begin
              do_pop       = 1'b1;
              occ_d        = occ_q - 1'b1;
              res_fired_d  = 1'b1;
              res_id_d     = cell_ent[0].task_id;
              ins_d        = cell_ent[0];
              ins_d.runs   = cell_ent[0].runs - 1'b1;
              rem_d        = cell_ent[0].period;
              fix_d        = 1'b1;
              if (cell_ent[0].period != '0) begin
                state_d = S_WALK;
              end
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DIV: begin
        if (div_done && div_done_per) begin
          ins_d.task_id = ins_q.task_id;
          ins_d.delta   = q_delay;
          ins_d.period  = q_period;
          ins_d.runs    = '0;
          rem_d         = q_delay;
          res_acc_d     = 1'b1;
          state_d       = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_more) begin
          rem_d = rem_q - walk_ent.delta;
          pos_d = pos_q + 1'b1;
        end else begin
          do_insert = 1'b1;
          occ_d     = occ_q + 1'b1;
          state_d   = fix_q ? S_FIX : S_DONE;
        end
      end
      S_FIX: begin
        do_bump = (cell_ent[0].delta == '0);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // the add's task id rides in the insert register until the divide is done
    if (state_q == S_IDLE && s_fire) begin
      ins_d.task_id = s_axis_tdata[7:0];
    end
  end

  // per-cell commands: each cell looks only at its own place relative to pos and count
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      cell_cmd[k] = CELL_HOLD;
      if (do_pop) begin
        cell_cmd[k] = CELL_LOAD_RIGHT;
      end else if (do_insert) begin
        if (POS_W'(k) == pos_q) begin
          cell_cmd[k] = CELL_LOAD_NEW;
        end else if (POS_W'(k) > pos_q && OCC_W'(k) <= occ_q) begin
          cell_cmd[k] = (POS_W'(k) == pos_q + 1'b1) ? CELL_LOAD_LEFT_SUB : CELL_LOAD_LEFT;
        end
      end else if (k == 0 && do_tick) begin
        cell_cmd[k] = CELL_TICK;
      end else if (k == 0 && do_bump) begin
        cell_cmd[k] = CELL_BUMP;
      end
    end
  end

  entry_t new_ent;
  always_comb begin
    new_ent       = ins_q;
    new_ent.delta = rem_q;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_ent, right_ent;
    if (g == 0) begin : g_first
      assign left_ent = new_ent;
    end else begin : g_mid
      assign left_ent = cell_ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_ent = cell_ent[g];
    end else begin : g_inner
      assign right_ent = cell_ent[g+1];
    end
    dlts_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd[g]),
      .left_i  (left_ent),
      .right_i (right_ent),
      .new_i   (new_ent),
      .sub_i   (rem_q),
      .entry_o (cell_ent[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign occ_ext = 32'(occ_q);

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    rem_q       <= rem_d;
    fix_q       <= fix_d;
    req_q       <= req_d;
    ins_q       <= ins_d;
    res_acc_q   <= res_acc_d;
    res_fired_q <= res_fired_d;
    res_id_q    <= res_id_d;
    if (state_q == S_IDLE && s_fire) begin
      delay_ms_q  <= s_axis_tdata[31:8];
      period_ms_q <= s_axis_tdata[55:32];
    end
    if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      out_acc_q    <= res_acc_q;
      out_fired_q  <= res_fired_q;
      out_id_q     <= res_id_q;
      out_queued_q <= occ_ext[4:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = {out_fired_q, out_acc_q};
  assign m_axis_tdata  = {3'b000, out_queued_q, out_id_q};

endmodule

// ----- tb/tb_delta_list_task_scheduler.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for delta_list_task_scheduler: directed rows, then random requests
// checked against a delta-list timer queue predictor. Depends on dlts_pkg and the RTL top.
module tb_delta_list_task_scheduler;
  import dlts_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int N_RANDOM     = 900;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int LASTING_MAX  = 10;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [TASK_W-1:0] id;
    logic [TIME_W-1:0] delay_ms;
    logic [TIME_W-1:0] period_ms;
  } sched_req_t;

  typedef struct packed {
    logic              accepted;
    logic              fired;
    logic [TASK_W-1:0] fired_id;
    logic [OCC_W-1:0]  queued;
  } sched_ans_t;

  typedef struct {
    sched_req_t rq;
    int         reps;
    bit         typed;
    sched_ans_t ans;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  delta_list_task_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // predicted timer queue
  logic [TASK_W-1:0] q_task   [DEPTH];
  logic [TIME_W-1:0] q_delta  [DEPTH];
  logic [TIME_W-1:0] q_period [DEPTH];
  logic [RUNS_W-1:0] q_runs   [DEPTH];
  int                q_count = 0;

  sched_ans_t awaited_answers[$];
  dir_row_t   dir_rows[$];

  int n_errors = 0;
  int n_items = 0;
  int n_stored = 0;
  int n_refused = 0;
  int n_fired = 0;
  int n_ticks = 0;
  int src_idle_pct = 30;
  int sink_stall_pct = 57;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic void sched_insert(input logic [TASK_W-1:0] id,
                                       input logic [TIME_W-1:0] dly,
                                       input logic [TIME_W-1:0] per,
                                       input logic [RUNS_W-1:0] runs);
    int pos = 0;
    while (pos < q_count && dly >= q_delta[pos]) begin
      dly -= q_delta[pos];
      pos++;
    end
    if (pos < q_count) q_delta[pos] -= dly;
    for (int k = q_count; k > pos; k--) begin
      q_task[k]   = q_task[k-1];
      q_delta[k]  = q_delta[k-1];
      q_period[k] = q_period[k-1];
      q_runs[k]   = q_runs[k-1];
    end
    q_task[pos]   = id;
    q_delta[pos]  = dly;
    q_period[pos] = per;
    q_runs[pos]   = runs;
    q_count++;
  endfunction

  function automatic sched_ans_t sched_step(input sched_req_t rq);
    sched_ans_t        a;
    logic [TASK_W-1:0] tid;
    logic [TIME_W-1:0] per;
    logic [RUNS_W-1:0] runs;
    a = '0;
    case (rq.req)
      REQ_TICK: begin
        if (q_count > 0) begin
          if (q_delta[0] != 0) q_delta[0]--;
          if (q_delta[0] == 0 && q_runs[0] != RUNS_MAX) q_runs[0]++;
        end
      end
      REQ_ADD: begin
        if (q_count < DEPTH) begin
          sched_insert(rq.id, TIME_W'(rq.delay_ms / TICK_MS),
                       TIME_W'(rq.period_ms / TICK_MS), '0);
          a.accepted = 1'b1;
        end
      end
      REQ_DISPATCH: begin
        if (q_count > 0 && q_runs[0] != 0) begin
          tid  = q_task[0];
          per  = q_period[0];
          runs = q_runs[0] - 1'b1;
          a.fired    = 1'b1;
          a.fired_id = tid;
          for (int k = 0; k + 1 < q_count; k++) begin
            q_task[k]   = q_task[k+1];
            q_delta[k]  = q_delta[k+1];
            q_period[k] = q_period[k+1];
            q_runs[k]   = q_runs[k+1];
          end
          q_count--;
          // periodic: reinsert one period out, keep the leftover runs
          if (per != 0) begin
            sched_insert(tid, per, per, runs);
            if (q_delta[0] == 0 && q_runs[0] != RUNS_MAX) q_runs[0]++;
          end
        end
      end
      default: ;
    endcase
    a.queued = q_count[OCC_W-1:0];
    return a;
  endfunction

  // entries that will stay for the rest of the run: periodic or far in the future
  function automatic int lasting_count();
    int unsigned due = 0;
    int          n = 0;
    for (int k = 0; k < q_count; k++) begin
      due += q_delta[k];
      if (q_period[k] != 0 || due > 2000) n++;
    end
    return n;
  endfunction

  function automatic sched_req_t make_plain(input logic [REQ_W-1:0] req);
    sched_req_t rq;
    rq.req       = req;
    rq.id        = TASK_W'($urandom);
    rq.delay_ms  = TIME_W'($urandom);
    rq.period_ms = TIME_W'($urandom);
    return rq;
  endfunction

  function automatic sched_req_t make_add();
    sched_req_t rq;
    int         pick;
    pick = $urandom_range(99);
    rq.req = REQ_ADD;
    rq.id  = TASK_W'($urandom);
    // limit long-lived entries so the queue keeps turning over
    if (lasting_count() < LASTING_MAX && pick < 6) begin
      rq.delay_ms  = TIME_W'($urandom);
      rq.period_ms = TIME_W'($urandom);
    end else if (lasting_count() < LASTING_MAX && pick < 18) begin
      rq.delay_ms  = TIME_W'($urandom_range(0, 80));
      rq.period_ms = TIME_W'($urandom_range(TICK_MS, 10 * TICK_MS));
    end else begin
      rq.delay_ms  = TIME_W'($urandom_range(0, 80));
      rq.period_ms = TIME_W'($urandom_range(0, TICK_MS - 1));
    end
    return rq;
  endfunction

  function automatic void field_check(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  task automatic put_row(input sched_req_t rq, input int reps, input bit typed,
                         input sched_ans_t ans);
    dir_row_t r;
    r.rq    = rq;
    r.reps  = reps;
    r.typed = typed;
    r.ans   = ans;
    dir_rows.push_back(r);
  endtask

  // Offer one request, wait for the transaction, then record its predicted answer.
  task automatic send_req(input sched_req_t rq, input bit typed, input sched_ans_t typed_ans);
    sched_ans_t a;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rq.period_ms, rq.delay_ms, rq.id};
    s_axis_tuser  <= rq.req;
    do @(posedge clk_i); while (!s_axis_tready);
    a = sched_step(rq);
    awaited_answers.push_back(typed ? typed_ans : a);
    if (rq.req != REQ_UNUSED) n_items++;
    if (rq.req == REQ_TICK) n_ticks++;
    if (rq.req == REQ_ADD && a.accepted) n_stored++;
    if (rq.req == REQ_ADD && !a.accepted) n_refused++;
    if (a.fired) n_fired++;
  endtask

  // result side: check each transaction, stall at random, honor hold-off requests
  always @(posedge clk_i) begin
    sched_ans_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t ns: result with nothing expected, got tuser 0x%0h tdata 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
        n_errors++;
      end else begin
        want = awaited_answers.pop_front();
        field_check("add_accepted", want.accepted, m_axis_tuser[0]);
        field_check("fired", want.fired, m_axis_tuser[1]);
        field_check("fired_task_id", want.fired_id, m_axis_tdata[7:0]);
        field_check("queued", want.queued, m_axis_tdata[12:8]);
      end
    end
    if (hold_served != hold_asks) begin
      hold_served   <= hold_asks;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin : stim
    int         start;
    int         pick;
    int         k;
    int unsigned n;
    bit         did_sat;
    bit         did_hold;
    sched_req_t rq;
    did_sat  = 1'b0;
    did_hold = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;

    // empty queue, unused code, extreme fields, fire and reinsert, full queue
    put_row('{REQ_TICK, 8'h00, 24'h0, 24'h0}, 1, 1'b1, '{1'b0, 1'b0, 8'h00, 5'd0});
    put_row('{REQ_DISPATCH, 8'h00, 24'h0, 24'h0}, 1, 1'b1, '{1'b0, 1'b0, 8'h00, 5'd0});
    put_row('{REQ_UNUSED, 8'hFF, 24'hFFFFFF, 24'hFFFFFF}, 1, 1'b1,
            '{1'b0, 1'b0, 8'h00, 5'd0});
    put_row('{REQ_ADD, 8'hFF, 24'hFFFFFF, 24'h0}, 1, 1'b1, '{1'b1, 1'b0, 8'h00, 5'd1});
    put_row('{REQ_ADD, 8'h00, 24'h0, 24'hFFFFFF}, 1, 1'b1, '{1'b1, 1'b0, 8'h00, 5'd2});
    put_row('{REQ_DISPATCH, 8'h00, 24'h0, 24'h0}, 1, 1'b1, '{1'b0, 1'b0, 8'h00, 5'd2});
    put_row('{REQ_TICK, 8'h00, 24'h0, 24'h0}, 1, 1'b1, '{1'b0, 1'b0, 8'h00, 5'd2});
    put_row('{REQ_DISPATCH, 8'h00, 24'h0, 24'h0}, 1, 1'b1, '{1'b0, 1'b1, 8'h00, 5'd2});
    put_row('{REQ_ADD, 8'h5A, 24'd9, 24'd9}, 1, 1'b1, '{1'b1, 1'b0, 8'h00, 5'd3});
    put_row('{REQ_ADD, 8'hA5, 24'd25, 24'd20}, 1, 1'b1, '{1'b1, 1'b0, 8'h00, 5'd4});
    put_row('{REQ_TICK, 8'h00, 24'h0, 24'h0}, 1, 1'b1, '{1'b0, 1'b0, 8'h00, 5'd4});
    put_row('{REQ_DISPATCH, 8'h00, 24'h0, 24'h0}, 1, 1'b1, '{1'b0, 1'b1, 8'h5A, 5'd3});
    put_row('{REQ_TICK, 8'h00, 24'h0, 24'h0}, 2, 1'b0, '0);
    put_row('{REQ_DISPATCH, 8'h00, 24'h0, 24'h0}, 1, 1'b0, '0);
    put_row('{REQ_ADD, 8'h3C, 24'd30, 24'd0}, DEPTH - 3, 1'b0, '0);
    put_row('{REQ_ADD, 8'hC3, 24'd0, 24'd0}, 1, 1'b1, '{1'b0, 1'b0, 8'h00, 5'd16});
    put_row('{REQ_TICK, 8'h00, 24'h0, 24'h0}, 2, 1'b0, '0);
    put_row('{REQ_DISPATCH, 8'h00, 24'h0, 24'h0}, 2, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].ans);
    end

    start = n_items;
    while (n_items - start < N_RANDOM) begin
      k = n_items - start;
      if (k < N_RANDOM / 3) begin
        src_idle_pct   = 30;
        sink_stall_pct = 57;
      end else if (k < 2 * N_RANDOM / 3) begin
        src_idle_pct   = 57;
        sink_stall_pct = 30;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end

      if (k >= N_RANDOM / 3 && !did_sat) begin
        // drive the head's run count into saturation, then release it
        did_sat = 1'b1;
        rq = make_plain(REQ_ADD);
        rq.delay_ms  = 24'd0;
        rq.period_ms = TIME_W'(TICK_MS);
        send_req(rq, 1'b0, '0);
        repeat (270) send_req(make_plain(REQ_TICK), 1'b0, '0);
        repeat (3) send_req(make_plain(REQ_DISPATCH), 1'b0, '0);
      end
      if (k >= 2 * N_RANDOM / 3 && !did_hold) begin
        did_hold = 1'b1;
        hold_asks++;
      end

      pick = $urandom_range(99);
      if (pick < 30) begin
        case ($urandom_range(19))
          0:                  send_req(make_plain(REQ_UNUSED), 1'b0, '0);
          1, 2, 3, 4, 5, 6, 7: send_req(make_plain(REQ_TICK), 1'b0, '0);
          8, 9, 10, 11, 12, 13: send_req(make_add(), 1'b0, '0);
          default:            send_req(make_plain(REQ_DISPATCH), 1'b0, '0);
        endcase
      end else if (pick < 65) begin
        // add a task, let it come due, dispatch it
        rq = make_add();
        send_req(rq, 1'b0, '0);
        n = rq.delay_ms / TICK_MS;
        if (n > 20) n = $urandom_range(0, 3);
        repeat (n + $urandom_range(0, 2)) send_req(make_plain(REQ_TICK), 1'b0, '0);
        repeat ($urandom_range(1, 2)) send_req(make_plain(REQ_DISPATCH), 1'b0, '0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_req(make_plain(REQ_TICK), 1'b0, '0);
        repeat ($urandom_range(1, 3)) send_req(make_plain(REQ_DISPATCH), 1'b0, '0);
      end else if (pick < 95) begin
        repeat (q_count) begin
          send_req(make_plain(REQ_TICK), 1'b0, '0);
          send_req(make_plain(REQ_DISPATCH), 1'b0, '0);
        end
      end else begin
        // fill to the brim and one more
        repeat (DEPTH + 1 - q_count) send_req(make_add(), 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests: %0d ticks, %0d adds stored, %0d refused on full queue,",
             n_items, n_ticks, n_stored, n_refused);
    $display("%0d tasks dispatched, including run-count saturation and a long result stall",
             n_fired);
    if (n_errors == 0) begin
      $display("delta_list_task_scheduler test passed");
    end else begin
      $display("delta_list_task_scheduler test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", awaited_answers.size());
    $display("delta_list_task_scheduler test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dlts_pkg.sv
rtl/dlts_div.sv
rtl/dlts_cell.sv
rtl/delta_list_task_scheduler.sv
tb/tb_delta_list_task_scheduler.sv
